[src/ptrf_pkg.sv]
`default_nettype none

package ptrf_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned RegW    = 48;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned FracW   = 14;
  localparam int unsigned ProdW   = 2 * CoordW;
  localparam int unsigned AccW    = ProdW + 2;
  localparam int unsigned SqW     = 2 * CoordW;
  localparam int unsigned DistW   = SqW + 2;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [IndexW-1:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_TRANS   = 3'd3,
    REG_CENTER  = 3'd4,
    REG_RANGE   = 3'd5
  } cfg_reg_e;

  localparam logic [RegW-1:0] RotXReset  = 48'h0000_0000_4000;
  localparam logic [RegW-1:0] RotYReset  = 48'h0000_4000_0000;
  localparam logic [RegW-1:0] RotZReset  = 48'h4000_0000_0000;
  localparam logic [CoordW-1:0] RangeReset = 16'hFFFF;
  localparam logic [SqW-1:0]    RangeSqReset = 32'hFFFE_0001;

  typedef struct packed {
    coord_t [2:0][2:0] rot;
    coord_t [2:0]      trans;
    coord_t [2:0]      ctr;
    logic [SqW-1:0]    range_sq;
  } cfg_t;

endpackage

`default_nettype wire

[src/ptrf_if.sv]
`default_nettype none

interface ptrf_point_if import ptrf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   frame_end;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output frame_end, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input frame_end, output ready);
endinterface

interface ptrf_result_if import ptrf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t world_x;
  coord_t world_y;
  coord_t world_z;
  logic   in_range;
  logic   frame_end_out;

  modport source (output valid, output world_x, output world_y, output world_z,
                  output in_range, output frame_end_out, input ready);
  modport sink   (input valid, input world_x, input world_y, input world_z,
                  input in_range, input frame_end_out, output ready);
endinterface

interface ptrf_cfg_if import ptrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] index;
  logic [RegW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/ptrf_cfg.sv]
`default_nettype none

module ptrf_cfg import ptrf_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  ptrf_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  logic [2:0][RegW-1:0] rot_row_q;
  logic [RegW-1:0]      trans_q;
  logic [RegW-1:0]      ctr_q;
  logic [CoordW-1:0]    range_q;
  logic [SqW-1:0]       range_sq_q;
  logic [SqW-1:0]       range_sq_d;
  logic                 wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid & cfg_i.ready;
  assign range_sq_d  = range_q * range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_row_q[0] <= RotXReset;
      rot_row_q[1] <= RotYReset;
      rot_row_q[2] <= RotZReset;
      trans_q      <= '0;
      ctr_q        <= '0;
      range_q      <= RangeReset;
      range_sq_q   <= RangeSqReset;
    end else begin
      range_sq_q <= range_sq_d;
      if (wr_en) begin
        case (cfg_i.index)
          REG_ROT_X:  rot_row_q[0] <= cfg_i.data;
          REG_ROT_Y:  rot_row_q[1] <= cfg_i.data;
          REG_ROT_Z:  rot_row_q[2] <= cfg_i.data;
          REG_TRANS:  trans_q      <= cfg_i.data;
          REG_CENTER: ctr_q        <= cfg_i.data;
          REG_RANGE:  range_q      <= cfg_i.data[CoordW-1:0];
          default: ;
        endcase
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    for (genvar k = 0; k < 3; k++) begin : g_col
      assign cfg_o.rot[i][k] = rot_row_q[i][CoordW*k +: CoordW];
    end
    assign cfg_o.trans[i] = trans_q[CoordW*i +: CoordW];
    assign cfg_o.ctr[i]   = ctr_q[CoordW*i +: CoordW];
  end
  assign cfg_o.range_sq = range_sq_q;

endmodule

`default_nettype wire

[src/point_transform_range_filter.sv]
`default_nettype none

// Rigid transform and radius crop for a 3D point stream. Each request carries one
// signed 16-bit point (1/128 m); the block returns world = R * p + t, rounded to
// nearest (ties up) and saturated to 16 bits, plus an in_range flag that is set when
// the squared distance to the configured center is at most the radius squared, and a
// copy of frame_end. Every point is returned; the consumer drops those out of range.
// Unless the result side stalls, the block takes one point per cycle, through a
// four-stage pipeline (multiply, accumulate and saturate, subtract and square,
// sum and compare). A stall on the result side stops the whole pipeline; ready
// follows the result side within the same cycle. Load the pose registers only
// while no point is in flight; a radius write is registered, then squared and registered.

module point_transform_range_filter import ptrf_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  ptrf_cfg_if.sink     cfg_i,
  ptrf_point_if.sink   point_i,
  ptrf_result_if.source result_o
);

  cfg_t cfg;

  ptrf_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  logic advance;
  logic v1_q, v2_q, v3_q, v4_q;
  logic fe1_q, fe2_q, fe3_q, fe4_q;

  logic signed [ProdW-1:0] prod_d [3][3];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [AccW-1:0]  acc    [3];
  logic signed [AccW-FracW-1:0] shr [3];
  coord_t                  w2_d [3];
  coord_t                  w2_q [3];
  logic signed [CoordW:0]  diff [3];
  logic signed [2*CoordW+1:0] sq_full [3];
  logic [SqW-1:0]          sq_q [3];
  coord_t                  w3_q [3];
  logic [DistW-1:0]        dist_sum;
  coord_t                  w4_q [3];
  logic                    in_range_q;
  coord_t                  pt [3];

  assign advance       = ~v4_q | result_o.ready;
  assign point_i.ready = advance;

  assign pt[0] = point_i.point_x;
  assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    for (genvar k = 0; k < 3; k++) begin : g_col
      assign prod_d[i][k] = $signed(cfg.rot[i][k]) * $signed(pt[k]);
    end

    assign acc[i] = AccW'(prod_q[i][0]) + AccW'(prod_q[i][1]) + AccW'(prod_q[i][2])
                  + $signed({{(AccW-CoordW-FracW){cfg.trans[i][CoordW-1]}},
                             cfg.trans[i], {FracW{1'b0}}})
                  + $signed(AccW'(1) << (FracW - 1));
    assign shr[i] = acc[i][AccW-1:FracW];

    always_comb begin
      if (shr[i] > $signed((AccW-FracW)'(16'sh7FFF))) begin
        w2_d[i] = 16'sh7FFF;
      end else if (shr[i] < -$signed((AccW-FracW)'(17'sh08000))) begin
        w2_d[i] = 16'sh8000;
      end else begin
        w2_d[i] = shr[i][CoordW-1:0];
      end
    end

    assign diff[i]    = $signed({w2_q[i][CoordW-1], w2_q[i]})
                      - $signed({cfg.ctr[i][CoordW-1], cfg.ctr[i]});
    assign sq_full[i] = diff[i] * diff[i];
  end

  assign dist_sum = DistW'(sq_q[0]) + DistW'(sq_q[1]) + DistW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (advance) begin
      v1_q <= point_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fe1_q <= point_i.frame_end;
      fe2_q <= fe1_q;
      fe3_q <= fe2_q;
      fe4_q <= fe3_q;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[i][k] <= prod_d[i][k];
        end
        w2_q[i] <= w2_d[i];
        w3_q[i] <= w2_q[i];
        sq_q[i] <= sq_full[i][SqW-1:0];
        w4_q[i] <= w3_q[i];
      end
      in_range_q <= (dist_sum <= DistW'(cfg.range_sq));
    end
  end

  assign result_o.valid         = v4_q;
  assign result_o.world_x       = w4_q[0];
  assign result_o.world_y       = w4_q[1];
  assign result_o.world_z       = w4_q[2];
  assign result_o.in_range      = in_range_q;
  assign result_o.frame_end_out = fe4_q;

endmodule

`default_nettype wire

[tb/sv/point_transform_range_filter_checker.sv]
`timescale 1ns / 1ps

module point_transform_range_filter_checker import ptrf_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  ptrf_cfg_if         cfg_i,
  ptrf_point_if       point_i,
  ptrf_result_if      result_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam longint CoordMax = longint'(2 ** (CoordW - 1)) - 1;
  localparam longint CoordMin = -longint'(2 ** (CoordW - 1));

  typedef struct packed {
    coord_t world_x;
    coord_t world_y;
    coord_t world_z;
    logic   in_range;
    logic   frame_end;
  } world_point_t;

  logic [RegW-1:0]   pose_row [3];
  logic [RegW-1:0]   pose_trans;
  logic [RegW-1:0]   crop_center;
  logic [CoordW-1:0] crop_radius;
  world_point_t      world_q [$];
  world_point_t      want;

  function automatic coord_t lane(input logic [RegW-1:0] word, input int idx);
    return coord_t'(word[CoordW*idx +: CoordW]);
  endfunction

  function automatic coord_t rotate_translate(input int row, input coord_t px, py, pz);
    longint acc;
    acc = longint'(lane(pose_trans, row)) <<< FracW;
    acc += longint'(lane(pose_row[row], 0)) * longint'(px);
    acc += longint'(lane(pose_row[row], 1)) * longint'(py);
    acc += longint'(lane(pose_row[row], 2)) * longint'(pz);
    // round half up, then floor
    acc = (acc + (longint'(1) <<< (FracW - 1))) >>> FracW;
    if (acc > CoordMax) acc = CoordMax;
    if (acc < CoordMin) acc = CoordMin;
    return coord_t'(acc);
  endfunction

  function automatic world_point_t transform_point(input coord_t px, py, pz,
                                                   input logic fe);
    world_point_t w;
    coord_t       wc [3];
    longint       d;
    longint       dist2;
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      wc[i] = rotate_translate(i, px, py, pz);
      d = longint'(wc[i]) - longint'(lane(crop_center, i));
      dist2 += d * d;
    end
    w.world_x   = wc[0];
    w.world_y   = wc[1];
    w.world_z   = wc[2];
    w.in_range  = dist2 <= longint'(crop_radius) * longint'(crop_radius);
    w.frame_end = fe;
    return w;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_row[0] = RotXReset;
      pose_row[1] = RotYReset;
      pose_row[2] = RotZReset;
      pose_trans  = '0;
      crop_center = '0;
      crop_radius = RangeReset;
      world_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_ROT_X:  pose_row[0] = cfg_i.data;
          REG_ROT_Y:  pose_row[1] = cfg_i.data;
          REG_ROT_Z:  pose_row[2] = cfg_i.data;
          REG_TRANS:  pose_trans  = cfg_i.data;
          REG_CENTER: crop_center = cfg_i.data;
          REG_RANGE:  crop_radius = cfg_i.data[CoordW-1:0];
          default: ;
        endcase
      end
      if (point_i.valid && point_i.ready) begin
        world_q.insert(world_q.size(),
                       transform_point(point_i.point_x, point_i.point_y,
                                       point_i.point_z, point_i.frame_end));
      end
      if (result_i.valid && result_i.ready) begin
        if (world_q.size() == 0) begin
          $error("result with no request outstanding");
          errors_o++;
        end else begin
          want = world_q[0];
          world_q.delete(0);
          check_field("world_x", want.world_x, result_i.world_x);
          check_field("world_y", want.world_y, result_i.world_y);
          check_field("world_z", want.world_z, result_i.world_z);
          check_field("in_range", want.in_range, result_i.in_range);
          check_field("frame_end_out", want.frame_end, result_i.frame_end_out);
        end
      end
      pending_o <= world_q.size();
    end
  end

endmodule

[tb/sv/point_transform_range_filter_test.sv]
`timescale 1ns / 1ps

module point_transform_range_filter_test;
  import ptrf_pkg::*;

  localparam int unsigned ResetCycles  = 10;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned BatchCount   = 6;
  localparam int unsigned BatchPoints  = 95;
  localparam longint      SimLimitNs   = 2_000_000;

  localparam coord_t CoordMax = 16'sh7fff;
  localparam coord_t CoordMin = 16'sh8000;
  localparam coord_t CoefHalf = 16'sh2000;

  localparam logic [IndexW-1:0] UnusedIdxLo = 3'd6;
  localparam logic [IndexW-1:0] UnusedIdxHi = 3'd7;

  localparam cfg_reg_e RegOrder [6] = '{REG_ROT_X, REG_ROT_Y, REG_ROT_Z,
                                        REG_TRANS, REG_CENTER, REG_RANGE};

  localparam int unsigned SrcIdlePct  [3] = '{7, 75, 0};
  localparam int unsigned SinkIdlePct [3] = '{75, 7, 0};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned errors;
  int unsigned pending;

  ptrf_cfg_if    cfg_if ();
  ptrf_point_if  point_if ();
  ptrf_result_if result_if ();

  point_transform_range_filter i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .point_i  (point_if),
    .result_o (result_if)
  );

  point_transform_range_filter_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_if),
    .point_i   (point_if),
    .result_i  (result_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic logic [RegW-1:0] pack3(input coord_t a, b, c);
    return {c, b, a};
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0, 1: return coord_t'($urandom);
      2: begin
        case ($urandom_range(4))
          0: return CoordMax;
          1: return CoordMin;
          2: return '0;
          3: return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      default: return coord_t'(int'($urandom_range(8000)) - 4000);
    endcase
  endfunction

  function automatic coord_t rand_coef();
    if ($urandom_range(4) == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic coord_t rand_offset();
    if ($urandom_range(3) == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(6000)) - 3000);
  endfunction

  task automatic hold_until_drained();
    point_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_point(input coord_t x, y, z, input logic fe);
    while ($urandom_range(99) < src_idle_pct) begin
      point_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    point_if.valid     <= 1'b1;
    point_if.point_x   <= x;
    point_if.point_y   <= y;
    point_if.point_z   <= z;
    point_if.frame_end <= fe;
    do @(posedge clk_i); while (!point_if.ready);
  endtask

  task automatic load_config(input logic [RegW-1:0] rx, ry, rz, tr, ct, rg,
                             input bit spare);
    logic [RegW-1:0] word_of [6];
    word_of = '{rx, ry, rz, tr, ct, rg};
    hold_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= RegOrder[i];
      cfg_if.data  <= word_of[i];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    if (spare) begin
      // unused index, must leave every register untouched
      cfg_if.index <= IndexW'($urandom_range(UnusedIdxHi, UnusedIdxLo));
      cfg_if.data  <= RegW'({$urandom, $urandom});
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_batch(input int unsigned n);
    load_config(pack3(rand_coef(), rand_coef(), rand_coef()),
                pack3(rand_coef(), rand_coef(), rand_coef()),
                pack3(rand_coef(), rand_coef(), rand_coef()),
                pack3(rand_offset(), rand_offset(), rand_offset()),
                pack3(rand_offset(), rand_offset(), rand_offset()),
                {$urandom, ($urandom_range(3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(8000))},
                $urandom_range(2) == 0);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) hold_until_drained();
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    point_if.valid     = 1'b0;
    point_if.point_x   = '0;
    point_if.point_y   = '0;
    point_if.point_z   = '0;
    point_if.frame_end = 1'b0;
    src_idle_pct       = SrcIdlePct[0];
    sink_idle_pct      = SinkIdlePct[0];

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity pose from reset, full-scale inputs
    send_point('0, '0, '0, 1'b0);
    send_point(CoordMax, CoordMax, CoordMax, 1'b1);
    send_point(CoordMin, CoordMin, CoordMin, 1'b0);
    send_point(CoordMax, CoordMin, 16'sd1, 1'b1);
    send_point(-16'sd1, 16'sd1, CoordMin, 1'b0);
    send_point(16'sh5555, 16'shaaaa, 16'sh2aaa, 1'b1);

    // half-scale diagonal: rounding ties go up
    load_config(pack3(CoefHalf, '0, '0), pack3('0, CoefHalf, '0), pack3('0, '0, CoefHalf),
                '0, '0, 48'd1, 1'b1);
    send_point(16'sd1, 16'sd1, 16'sd1, 1'b0);
    send_point(-16'sd1, -16'sd1, -16'sd1, 1'b1);
    send_point(16'sd3, -16'sd3, '0, 1'b0);
    send_point(16'sd1, '0, '0, 1'b1);

    // most negative coefficients, saturation both ways, radius zero with junk above
    load_config(pack3(CoordMin, CoordMin, CoordMin), pack3(CoordMin, CoordMin, CoordMin),
                pack3(CoordMin, CoordMin, CoordMin), pack3(CoordMax, CoordMax, CoordMax),
                pack3(CoordMin, CoordMin, CoordMin), 48'habcd_1234_0000, 1'b0);
    send_point(CoordMax, CoordMax, CoordMax, 1'b0);
    send_point(CoordMin, CoordMin, CoordMin, 1'b1);
    send_point('0, '0, '0, 1'b0);

    // most positive coefficients, widest radius
    load_config(pack3(CoordMax, CoordMax, CoordMax), pack3(CoordMax, CoordMax, CoordMax),
                pack3(CoordMax, CoordMax, CoordMax), pack3(CoordMin, CoordMin, CoordMin),
                pack3(CoordMax, CoordMax, CoordMax), {32'hffff_ffff, RangeReset}, 1'b1);
    send_point(CoordMax, CoordMax, CoordMax, 1'b1);
    send_point(CoordMin, CoordMin, CoordMin, 1'b0);
    send_point('0, '0, '0, 1'b1);

    // radius boundary: inclusive at exactly the radius
    load_config(RotXReset, RotYReset, RotZReset, '0, pack3(16'sd100, -16'sd50, '0),
                48'd100, 1'b0);
    send_point(16'sd160, 16'sd30, '0, 1'b0);
    send_point(16'sd161, 16'sd30, '0, 1'b1);
    send_point(16'sd100, -16'sd50, 16'sd100, 1'b0);
    send_point(16'sd100, -16'sd50, -16'sd101, 1'b1);

    for (int p = 0; p < 3; p++) begin
      src_idle_pct  = SrcIdlePct[p];
      sink_idle_pct = SinkIdlePct[p];
      for (int b = 0; b < BatchCount; b++) run_batch(BatchPoints);
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("point_transform_range_filter regression: pass");
    end else begin
      $display("point_transform_range_filter regression: fail");
    end
    $finish;
  end

  initial begin
    #SimLimitNs;
    $display("point_transform_range_filter regression: fail");
    $finish;
  end

endmodule
